// ===== sv/box_blur_row_filter_defines.svh =====
// Assertion macros shared by the box blur row filter RTL.
`ifndef BOX_BLUR_ROW_FILTER_DEFINES_SVH
`define BOX_BLUR_ROW_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bbr_pkg.sv =====
// Types and constants shared by the box blur row filter modules.
`timescale 1ns / 1ps
`default_nettype none
package bbr_pkg;

  localparam int PIX_W       = 8;
  localparam int COL_W       = 11;
  localparam int AVG_W       = 16;
  localparam int SUM_W       = 19;
  localparam int RW_W        = 12;
  localparam int RAD_W       = 10;
  localparam int DIV_W       = RAD_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - COL_W - AVG_W;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int STEP_CNT_W  = $clog2(AVG_W);

  localparam logic [CFG_IDX_W-1:0]  REG_ROW_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_RADIUS      = 2'd1;
  localparam logic [RW_W-1:0]       ROW_WIDTH_RESET = 12'd2048;
  localparam logic [RAD_W-1:0]      RADIUS_RESET    = 10'd25;
  localparam logic [STEP_CNT_W-1:0] STEP_LAST       = 4'd15;

  // One averaging job handed from the front end to the divider.
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [SUM_W-1:0] sum;
    logic [DIV_W-1:0] divisor;
    logic             row_last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_DONE
  } div_state_t;

endpackage
`default_nettype wire

// ===== sv/bbr_front.sv =====
// Front end: config registers, pixel history, running window sum, job issue.
`timescale 1ns / 1ps
`default_nettype none
module bbr_front import bbr_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_addr,
  input  wire  [CFG_DATA_W-1:0] cfg_wdata,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [IN_TDATA_W-1:0] in_tdata,
  input  q_status_t             q_status,
  output logic                  q_push,
  output job_t                  q_job
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CW     = ((ADDR_W > RW_W) ? ADDR_W : RW_W) + 1;

  logic [RW_W-1:0]   row_width_r, row_width_nxt;
  logic [RAD_W-1:0]  radius_r, radius_nxt;
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              rd_valid_r, rd_valid_nxt;
  logic [PIX_W-1:0]  rd_data_r;
  logic [PIX_W-1:0]  hist_r [MAX_WIDTH];

  logic [DIV_W-1:0]  span;
  logic [CW-1:0]     col_x, span_x, col_inc, width_eff, rd_addr_x, col_centre;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  pixel;
  logic [SUM_W-1:0]  sum_upd;
  logic              accept, is_last, emit, drop_old;
  logic              cfg_hit_rw, cfg_hit_rad, cfg_restart;

  assign pixel      = in_tdata[PIX_W-1:0];
  assign span       = {radius_r, 1'b0};
  assign col_x      = CW'(col_r);
  assign span_x     = CW'(span);
  assign col_inc    = col_x + CW'(1);
  assign rd_addr_x  = col_x - span_x - CW'(1);
  assign rd_addr    = rd_addr_x[ADDR_W-1:0];
  assign col_centre = col_x - CW'(radius_r);

  always_comb begin
    if (row_width_r == '0) begin
      width_eff = CW'(1);
    end else if (CW'(row_width_r) > CW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = CW'(row_width_r);
    end
  end

  assign is_last  = (col_inc >= width_eff);
  assign emit     = (col_x >= span_x);
  assign drop_old = (col_x > span_x);

  // Stall while the history read for this column is in flight or the queue is full.
  assign in_tready = rd_valid_r && !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign sum_upd   = sum_r + SUM_W'(pixel) - (drop_old ? SUM_W'(rd_data_r) : SUM_W'(0));

  assign q_push         = accept && emit;
  assign q_job.column   = col_centre[COL_W-1:0];
  assign q_job.sum      = sum_upd;
  assign q_job.divisor  = span + DIV_W'(1);
  assign q_job.row_last = is_last;

  assign cfg_hit_rw  = cfg_we && (cfg_addr == REG_ROW_WIDTH);
  assign cfg_hit_rad = cfg_we && (cfg_addr == REG_RADIUS);
  assign cfg_restart = cfg_hit_rw || cfg_hit_rad;

  always_comb begin
    row_width_nxt = cfg_hit_rw  ? cfg_wdata[RW_W-1:0]  : row_width_r;
    radius_nxt    = cfg_hit_rad ? cfg_wdata[RAD_W-1:0] : radius_r;
    col_nxt       = col_r;
    sum_nxt       = sum_r;
    // Drop the prefetched history byte whenever the column or the radius moves.
    rd_valid_nxt  = !(accept || cfg_we);
    if (cfg_restart) begin
      col_nxt = '0;
      sum_nxt = '0;
    end else if (accept) begin
      col_nxt = is_last ? '0 : col_inc[ADDR_W-1:0];
      sum_nxt = is_last ? '0 : sum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RESET;
      radius_r    <= RADIUS_RESET;
      col_r       <= '0;
      sum_r       <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      row_width_r <= row_width_nxt;
      radius_r    <= radius_nxt;
      col_r       <= col_nxt;
      sum_r       <= sum_nxt;
      rd_valid_r  <= rd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_r[col_r] <= pixel;
    end
    rd_data_r <= hist_r[rd_addr];
  end

endmodule
`default_nettype wire

// ===== sv/bbr_queue.sv =====
// Short job queue between the front end and the divider.
`timescale 1ns / 1ps
`default_nettype none
module bbr_queue import bbr_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       push,
  input  job_t      push_job,
  input  wire       pop,
  output job_t      head,
  output q_status_t status
);

  job_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bbr_div.sv =====
// Back end: bit-serial divider for the Q8.8 average and the output register.
`timescale 1ns / 1ps
`default_nettype none
module bbr_div import bbr_pkg::*; (
  input  wire                    clk,
  input  wire                    rst_n,
  input  q_status_t              q_status,
  input  job_t                   q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  div_state_t            state_r, state_nxt;
  logic [DIV_W-1:0]      rem_r, div_r;
  logic [AVG_W-1:0]      quo_r;
  logic [COL_W-1:0]      col_r;
  logic                  last_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]      out_col_r;
  logic [AVG_W-1:0]      out_avg_r;
  logic                  out_last_r;

  logic                  step_en, load_out, out_free;
  logic [DIV_W:0]        trial, rem_step;
  logic                  q_bit;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: if (!q_status.empty) state_nxt = DV_RUN;
      DV_RUN:  if (cnt_r == STEP_LAST) state_nxt = DV_DONE;
      DV_DONE: if (out_free) state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    step_en  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      DV_IDLE: q_pop    = !q_status.empty;
      DV_RUN:  step_en  = 1'b1;
      DV_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign trial    = {rem_r, quo_r[AVG_W-1]};
  assign q_bit    = (trial >= {1'b0, div_r});
  assign rem_step = q_bit ? (trial - {1'b0, div_r}) : trial;

  assign out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DV_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Quotient fits 16 bits, so the top bits of sum*256 seed the remainder.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem_r  <= q_head.sum[SUM_W-1 -: DIV_W];
      quo_r  <= {q_head.sum[PIX_W-1:0], PIX_W'(0)};
      div_r  <= q_head.divisor;
      col_r  <= q_head.column;
      last_r <= q_head.row_last;
      cnt_r  <= '0;
    end else if (step_en) begin
      rem_r <= rem_step[DIV_W-1:0];
      quo_r <= {quo_r[AVG_W-2:0], q_bit};
      cnt_r <= cnt_r + STEP_CNT_W'(1);
    end
    if (load_out) begin
      out_col_r  <= col_r;
      out_avg_r  <= quo_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_avg_r, out_col_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== sv/box_blur_row_filter.sv =====
// Top level of the box blur row filter: front end, job queue and divider.
//
// Usage: pixels of image rows arrive in raster order on the in_ stream, one
// 8-bit pixel per transaction. For each pixel at column p >= 2r the block
// sends one transaction on the out_ stream: the column p-r, the box average
// over the 2r+1 pixels centred there as truncated Q8.8, and tlast on the
// last interior column of the row. Edge columns produce no transaction.
// row_width (index 0) and radius (index 1) are written on the cfg_ port
// while the block is idle; each write restarts the current row.
// The front end waits after each pixel for a registered read of the pixel
// history memory (the sample leaving the window) before it takes the next.
// The bit-serial divider loads a job, works out the 16 quotient bits and
// hands the result over before it pops the next job from the queue.
// A two-entry queue lets the front end run ahead of the divider; when the
// receiver stalls the result holds in the output register, the divider then
// the queue fill, and in_tready falls. Reset (rst_n low, synchronous) loads
// row_width 2048 and radius 25, empties the queue and clears the row state.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_row_filter_defines.svh"
module box_blur_row_filter import bbr_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_addr,
  input  wire  [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [IN_TDATA_W-1:0]  in_tdata,   // [7:0] pixel
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [10:0] column, [26:11] average, zero above
  output logic                   out_tlast
);

  q_status_t q_status;
  job_t      q_job, q_head;
  logic      q_push, q_pop;
  logic      in_fire;

  assign in_fire = in_tvalid && in_tready;

  // Front: update the window sum and issue one job per interior column.
  bbr_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // Queue: decouple the pixel side from the divider.
  bbr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  // Back: divide sum*256 by 2r+1 and hold the result for the receiver.
  bbr_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `BBR_ASSERT_NOW(a_no_push_full, q_push, !q_status.full, "job pushed into full queue")
  `BBR_ASSERT_NOW(a_no_pop_empty, q_pop, !q_status.empty, "job popped from empty queue")
  `BBR_ASSERT_NEXT(a_history_gap, in_fire, !in_tready, "pixel taken before history read")
  `BBR_ASSERT_NEXT(a_cfg_refetch, cfg_we, !in_tready, "pixel taken with stale history read")

endmodule
`default_nettype wire

// ===== tb/bbr_blur_checker.sv =====
// Checker for the box blur row filter: predicts each averaged pixel and compares it.
`timescale 1ns / 1ps
module bbr_blur_checker import bbr_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_addr,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                   in_tvalid,
  input  wire                   in_tready,
  input  wire [IN_TDATA_W-1:0]  in_tdata,
  input  wire                   out_tvalid,
  input  wire                   out_tready,
  input  wire [OUT_TDATA_W-1:0] out_tdata,
  input  wire                   out_tlast,
  output int                    mismatches,
  output int                    awaited
);

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [AVG_W-1:0] average;
    logic             row_last;
  } blur_result_t;

  blur_result_t     awaited_averages[$];
  logic [RW_W-1:0]  row_width;
  logic [RAD_W-1:0] radius;
  logic [SUM_W-1:0] window_sum;
  int unsigned      column;
  logic [PIX_W-1:0] row_pixels [MAX_WIDTH];
  int               errors = 0;

  task automatic restart_row();
    window_sum = '0;
    column = 0;
  endtask

  task automatic predict_average(input logic [PIX_W-1:0] pix);
    int unsigned  eff_w;
    int unsigned  span;
    int unsigned  p;
    int unsigned  avg;
    blur_result_t res;
    eff_w = (row_width == 0) ? 1 : ((row_width > MAX_WIDTH) ? MAX_WIDTH : row_width);
    span = 2 * radius;
    if (column >= eff_w) restart_row();
    p = column;
    row_pixels[p] = pix;
    window_sum = window_sum + pix;
    // drop the pixel that has just left the window
    if (p >= span + 1) window_sum = window_sum - row_pixels[p - span - 1];
    if (p >= span) begin
      avg = (window_sum * 256) / (span + 1);
      res.column = COL_W'(p - radius);
      res.average = avg[AVG_W-1:0];
      res.row_last = (p + 1 >= eff_w);
      awaited_averages.push_back(res);
    end
    if (p + 1 >= eff_w) restart_row();
    else column = p + 1;
  endtask

  task automatic check_average(input logic [OUT_TDATA_W-1:0] data, input logic last);
    blur_result_t got;
    blur_result_t want;
    got.column = data[COL_W-1:0];
    got.average = data[COL_W +: AVG_W];
    got.row_last = last;
    if (awaited_averages.size() == 0) begin
      $display("%0t: result with none expected: column %0d average %0d row_last %0b",
               $time, got.column, got.average, got.row_last);
      errors++;
    end else begin
      want = awaited_averages.pop_front();
      if (got.column !== want.column || got.average !== want.average ||
          got.row_last !== want.row_last || data[OUT_TDATA_W-1:COL_W+AVG_W] !== '0) begin
        $display("%0t: expected column %0d average %0d row_last %0b, got column %0d average %0d row_last %0b pad %0h",
                 $time, want.column, want.average, want.row_last,
                 got.column, got.average, got.row_last, data[OUT_TDATA_W-1:COL_W+AVG_W]);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      row_width = ROW_WIDTH_RESET;
      radius = RADIUS_RESET;
      restart_row();
      awaited_averages.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_ROW_WIDTH) begin
          row_width = cfg_wdata[RW_W-1:0];
          restart_row();
        end else if (cfg_addr == REG_RADIUS) begin
          radius = cfg_wdata[RAD_W-1:0];
          restart_row();
        end
      end
      if (in_tvalid && in_tready) predict_average(in_tdata[PIX_W-1:0]);
      if (out_tvalid && out_tready) check_average(out_tdata, out_tlast);
    end
    mismatches <= errors;
    awaited <= awaited_averages.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the box blur row filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import bbr_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  // Cover pixels still in the front end and the divider after the last result.
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PIXELS  = 1000;
  // Indexes beyond the register map: writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // [7:0] pixel
  logic                   out_tready = 1'b0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire  [OUT_TDATA_W-1:0] out_tdata;        // [10:0] column, [26:11] average, zero above
  wire                    out_tlast;

  int mismatches;
  int awaited;
  int send_idle_pct = 29;
  int recv_idle_pct = 65;
  int quiet_cycles  = 0;

  always #(HALF_PERIOD) clk = ~clk;

  box_blur_row_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  bbr_blur_checker blur_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  // Receiver: stall at random, at the rate of the current era.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Offer one pixel, after an optional random gap, and hold it until accepted.
  // Leave tvalid high afterwards so back-to-back transactions need no toggle.
  task automatic send_pixel(input logic [IN_TDATA_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_pixels(input int count);
    for (int i = 0; i < count; i++) send_pixel(pick_pixel());
  endtask

  // Drain: lower tvalid, wait for every awaited result, then let the pipe empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Write both registers on an idle block, in random order.
  task automatic set_config(input logic [RW_W-1:0] width, input logic [RAD_W-1:0] rad);
    settle();
    if ($urandom_range(1)) begin
      write_reg(REG_ROW_WIDTH, CFG_DATA_W'(width));
      write_reg(REG_RADIUS, CFG_DATA_W'(rad));
    end else begin
      write_reg(REG_RADIUS, CFG_DATA_W'(rad));
      write_reg(REG_ROW_WIDTH, CFG_DATA_W'(width));
    end
  endtask

  initial begin
    int era;
    int width;
    int rad;
    int eff;
    int rows;
    int count;
    int sent;
    sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Narrow window on a short row, pixel extremes at both ends.
    set_config(12'd5, 10'd1);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);

    // Radius zero: each pixel returns as itself in Q8.8, and the third ends the row.
    set_config(12'd3, 10'd0);
    send_pixel(8'd255);
    send_pixel(8'd1);
    send_pixel(8'd128);

    // Window wider than the row: no result, though rows still wrap.
    set_config(12'd4, 10'd2);
    send_pixels(4);

    // Zero width behaves as a one-pixel row.
    set_config(12'd0, 10'd0);
    send_pixels(3);

    // A write part-way through a row restarts it at column 0.
    set_config(12'd6, 10'd1);
    send_pixels(4);
    settle();
    write_reg(REG_RADIUS, 12'd1);
    send_pixels(6);

    // Writes to spare indexes are dropped and leave the row running.
    send_pixels(3);
    settle();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '0);
    send_pixels(3);

    // Width above the maximum saturates; with radius zero the early columns
    // of the long row come back one by one and none ends the row.
    set_config(12'hFFF, 10'd0);
    send_pixels(8);

    // Random part: mostly short rows and small windows, a few wide ones.
    for (era = 0; era < 3; era++) begin
      if (era == 1) begin
        send_idle_pct = 65;
        recv_idle_pct = 29;
      end else if (era == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      while (sent < (era + 1) * RANDOM_PIXELS / 3) begin
        width = ($urandom_range(9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
        rad   = ($urandom_range(7) == 0) ? $urandom_range(9, 200) : $urandom_range(0, 8);
        set_config(width[RW_W-1:0], rad[RAD_W-1:0]);
        eff   = width;
        rows  = (eff > 40) ? 1 : $urandom_range(1, 4);
        // Sometimes stop mid-row so the next write cuts it short.
        count = eff * rows + (($urandom_range(3) == 0) ? $urandom_range(0, eff - 1) : 0);
        send_pixels(count);
        sent += count;
      end
    end

    settle();
    if (mismatches == 0 && awaited == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
